>>> design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Beat structs, bracket kinds, verdict codes and the character decoders.
// ----------------------------------------------------------------------------
package bbc_pkg;

	// Bracket kind as stored on the stack
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ROUND  = 2'd0;
	localparam kind_t KIND_CURLY  = 2'd1;
	localparam kind_t KIND_SQUARE = 2'd2;
	localparam kind_t KIND_NONE   = 2'd3;

	// Verdict codes
	typedef logic [2:0] status_t;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_EMPTY    = 3'd1;
	localparam status_t ST_MISMATCH = 3'd2;
	localparam status_t ST_UNCLOSED = 3'd3;
	localparam status_t ST_OVERFLOW = 3'd4;

	// Character codes
	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} char_beat_t;

	typedef struct packed {
		logic    is_valid;
		status_t status_code;
	} verdict_beat_t;

	function automatic kind_t opener_kind(input logic [7:0] c);
		unique case (c)
			CH_OPEN_ROUND:  opener_kind = KIND_ROUND;
			CH_OPEN_CURLY:  opener_kind = KIND_CURLY;
			CH_OPEN_SQUARE: opener_kind = KIND_SQUARE;
			default:        opener_kind = KIND_NONE;
		endcase
	endfunction

	function automatic kind_t closer_kind(input logic [7:0] c);
		unique case (c)
			CH_CLOSE_ROUND:  closer_kind = KIND_ROUND;
			CH_CLOSE_CURLY:  closer_kind = KIND_CURLY;
			CH_CLOSE_SQUARE: closer_kind = KIND_SQUARE;
			default:         closer_kind = KIND_NONE;
		endcase
	endfunction

endpackage

>>> design/bracket_balance_checker_core.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_core: streaming balanced-bracket checker
// One character per beat; a verdict beat follows the last character.
// ----------------------------------------------------------------------------
// The verdict beat is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one character per cycle while char_stall is low; the top of stack sits in a register
// and the entry below it is prefetched from the one-read one-write stack memory.
// A two-entry output buffer keeps input flowing while a verdict waits.
// Reset: asynchronous; count, error and output valids clear at once; the
// stack memory is not cleared (entries are read only below the count).
module bracket_balance_checker_core
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_stall,
	input  char_beat_t    char_beat,
	output logic          verdict_valid,
	input  logic          verdict_stall,
	output verdict_beat_t verdict_beat
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// Stack memory holds every entry below the top
	kind_t         stack_mem [STACK_DEPTH];

	logic [CW-1:0] cnt_q, cnt_n;
	status_t       err_q, err_n;
	kind_t         tos_q, tos_n;

	logic          accept;
	kind_t         ok_kind, ck_kind;
	kind_t         below;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	kind_t         rd_data_s1;
	logic          fwd_s1;
	kind_t         fwd_data_s1;

	logic          res_valid;
	verdict_beat_t res_beat;
	status_t       res_code;

	logic          skid_valid_q;
	verdict_beat_t skid_beat_q;
	logic          out_valid_q;
	verdict_beat_t out_beat_q;
	logic          out_free;

	assign accept  = char_valid && !char_stall;
	assign ok_kind = opener_kind(char_beat.char_in);
	assign ck_kind = closer_kind(char_beat.char_in);
	assign below   = fwd_s1 ? fwd_data_s1 : rd_data_s1;

	// Stack update for one character
	always_comb begin
		cnt_n     = cnt_q;
		err_n     = err_q;
		tos_n     = tos_q;
		wr_en     = 1'b0;
		wr_addr   = cnt_q[AW-1:0] - AW'(1);
		res_valid = 1'b0;
		res_code  = ST_OK;
		if (accept) begin
			if (err_q == ST_OK) begin
				if (ok_kind != KIND_NONE) begin
					if (cnt_q == CW'(STACK_DEPTH)) begin
						err_n = ST_OVERFLOW;
					end else begin
						// old top moves down into memory
						wr_en = (cnt_q != '0);
						tos_n = ok_kind;
						cnt_n = cnt_q + CW'(1);
					end
				end else if (ck_kind != KIND_NONE) begin
					if (cnt_q == '0) begin
						err_n = ST_EMPTY;
					end else if (tos_q == ck_kind) begin
						tos_n = below;
						cnt_n = cnt_q - CW'(1);
					end else begin
						err_n = ST_MISMATCH;
					end
				end
			end
			if (char_beat.last_char) begin
				res_valid = 1'b1;
				res_code  = err_n;
				if (err_n == ST_OK && cnt_n != '0) begin
					res_code = ST_UNCLOSED;
				end
				cnt_n = '0;
				err_n = ST_OK;
			end
		end
	end

	assign res_beat.is_valid    = (res_code == ST_OK);
	assign res_beat.status_code = res_code;

	// Prefetch the entry below the next top
	assign rd_addr = AW'(cnt_n - CW'(2));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= tos_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1  <= stack_mem[rd_addr];
		fwd_data_s1 <= tos_q;
	end

	// Write and read of the same entry: forward the written kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else begin
			fwd_s1 <= wr_en && (wr_addr == rd_addr);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ST_OK;
		end else begin
			cnt_q <= cnt_n;
			err_q <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_n;
	end

	// Output register plus skid entry
	assign out_free   = !out_valid_q || !verdict_stall;
	assign char_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= res_valid;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_beat_q  <= skid_beat_q;
				skid_beat_q <= res_beat;
			end else begin
				out_beat_q <= res_beat;
			end
		end else if (res_valid) begin
			skid_beat_q <= res_beat;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict_beat  = out_beat_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without output entry");

	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q != ST_OK && !char_beat.last_char) |=>
		($stable(cnt_q) && $stable(err_q)))
		else $error("state changed after an error");

	a_push_top: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q == ST_OK && !char_beat.last_char && ok_kind != KIND_NONE
		&& cnt_q != CW'(STACK_DEPTH)) |=> (tos_q == $past(ok_kind)))
		else $error("pushed kind not on top");

endmodule

>>> dv/bracket_balance_checker_core_tb.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_core_tb: self-checking bench for the bracket checker
// Streams directed and random strings through the core. A scoreboard tracks
// its own copy of the bracket stack and compares every verdict beat in order.
// The run goes through four traffic phases with random idling and stalls.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core_tb;
	import bbc_pkg::*;

	localparam int DEPTH = 64;

	// Running bracket stack and queue of verdicts still to come
	class verdict_scoreboard;
		kind_t         stack_mem[DEPTH];
		int unsigned   depth;
		status_t       err;
		verdict_beat_t pending_q[$];
		int            errors;

		function new();
			depth  = 0;
			err    = ST_OK;
			errors = 0;
		endfunction

		// Accepted character beat: update stack, queue a verdict on the last one
		function void note_char(char_beat_t b);
			kind_t         opn;
			kind_t         cls;
			status_t       code;
			verdict_beat_t v;
			opn = KIND_NONE;
			cls = KIND_NONE;
			case (b.char_in)
				CH_OPEN_ROUND:   opn = KIND_ROUND;
				CH_OPEN_CURLY:   opn = KIND_CURLY;
				CH_OPEN_SQUARE:  opn = KIND_SQUARE;
				CH_CLOSE_ROUND:  cls = KIND_ROUND;
				CH_CLOSE_CURLY:  cls = KIND_CURLY;
				CH_CLOSE_SQUARE: cls = KIND_SQUARE;
				default:         ;
			endcase
			// first error freezes the string
			if (err == ST_OK) begin
				if (opn != KIND_NONE) begin
					if (depth >= DEPTH) begin
						err = ST_OVERFLOW;
					end else begin
						stack_mem[depth] = opn;
						depth++;
					end
				end else if (cls != KIND_NONE) begin
					if (depth == 0)
						err = ST_EMPTY;
					else if (stack_mem[depth - 1] == cls)
						depth--;
					else
						err = ST_MISMATCH;
				end
			end
			if (b.last_char) begin
				code = err;
				if (code == ST_OK && depth != 0)
					code = ST_UNCLOSED;
				v.is_valid    = (code == ST_OK);
				v.status_code = code;
				pending_q.push_back(v);
				depth = 0;
				err   = ST_OK;
			end
		endfunction

		// Accepted verdict beat against the oldest expectation
		function void check_verdict(verdict_beat_t got);
			verdict_beat_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected verdict is_valid=%0d status=%0d",
					$time, got.is_valid, got.status_code);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.is_valid !== want.is_valid) begin
				$display("%0t: is_valid expected %0d actual %0d",
					$time, want.is_valid, got.is_valid);
				errors++;
			end
			if (got.status_code !== want.status_code) begin
				$display("%0t: status_code expected %0d actual %0d",
					$time, want.status_code, got.status_code);
				errors++;
			end
		endfunction
	endclass

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          char_valid    = 1'b0;
	logic          char_stall;
	char_beat_t    char_beat     = '0;
	logic          verdict_valid;
	logic          verdict_stall = 1'b0;
	verdict_beat_t verdict_beat;

	verdict_scoreboard sb;
	logic [7:0]        txt[$];
	int                idle_pct  = 0;
	int                stall_pct = 0;
	int                n_sent    = 0;

	bracket_balance_checker_core #(
		.STACK_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_beat    (char_beat),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_beat (verdict_beat)
	);

	always #2 clk = ~clk;

	// Receiver back-pressure
	always @(posedge clk) begin
		verdict_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Verdict monitor
	always @(posedge clk) begin
		if (arst_n && verdict_valid && !verdict_stall)
			sb.check_verdict(verdict_beat);
	end

	// Hard limit on run time
	initial begin
		#2000000;
		$display("bracket_balance_checker_core_tb NOT OK");
		$finish;
	end

	function automatic logic [7:0] rand_bracket();
		case ($urandom_range(0, 5))
			0:       return CH_OPEN_ROUND;
			1:       return CH_CLOSE_ROUND;
			2:       return CH_OPEN_CURLY;
			3:       return CH_CLOSE_CURLY;
			4:       return CH_OPEN_SQUARE;
			default: return CH_CLOSE_SQUARE;
		endcase
	endfunction

	function automatic logic [7:0] opener_of(int k);
		case (k)
			0:       return CH_OPEN_ROUND;
			1:       return CH_OPEN_CURLY;
			default: return CH_OPEN_SQUARE;
		endcase
	endfunction

	function automatic logic [7:0] closer_of(int k);
		case (k)
			0:       return CH_CLOSE_ROUND;
			1:       return CH_CLOSE_CURLY;
			default: return CH_CLOSE_SQUARE;
		endcase
	endfunction

	// Any byte that is not a bracket
	function automatic logic [7:0] noise_byte();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_OPEN_ROUND || c == CH_CLOSE_ROUND || c == CH_OPEN_CURLY ||
			c == CH_CLOSE_CURLY || c == CH_OPEN_SQUARE || c == CH_CLOSE_SQUARE);
		return c;
	endfunction

	// Send txt as one string, last flag on its final byte
	task automatic send_txt();
		char_beat_t b;
		for (int i = 0; i < txt.size(); i++) begin
			while ($urandom_range(0, 99) < idle_pct) begin
				char_valid <= 1'b0;
				@(posedge clk);
			end
			b.char_in   = txt[i];
			b.last_char = (i == txt.size() - 1);
			char_valid <= 1'b1;
			char_beat  <= b;
			@(posedge clk);
			while (char_stall)
				@(posedge clk);
			sb.note_char(b);
			n_sent++;
		end
	endtask

	task automatic send_str(input string s);
		txt.delete();
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
		send_txt();
	endtask

	// Hold off the sender until every verdict is in
	task automatic drain();
		char_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	// Properly nested string with noise bytes mixed in
	task automatic build_nested(input int n_open, input int dmax);
		int kinds[$];
		int opened;
		opened = 0;
		txt.delete();
		while (opened < n_open || kinds.size() > 0) begin
			if ($urandom_range(0, 3) == 0)
				txt.push_back(noise_byte());
			if (opened < n_open && kinds.size() < dmax &&
				(kinds.size() == 0 || $urandom_range(0, 1))) begin
				kinds.push_back($urandom_range(0, 2));
				txt.push_back(opener_of(kinds[$]));
				opened++;
			end else begin
				txt.push_back(closer_of(kinds.pop_back()));
			end
		end
	endtask

	// n_open openers, then closers in matching order
	task automatic build_deep(input int n_open, input int n_close);
		int kinds[$];
		txt.delete();
		for (int i = 0; i < n_open; i++) begin
			kinds.push_back($urandom_range(0, 2));
			txt.push_back(opener_of(kinds[$]));
		end
		for (int i = 0; i < n_close && kinds.size() > 0; i++)
			txt.push_back(closer_of(kinds.pop_back()));
	endtask

	// Break a nested string in one of several ways
	task automatic corrupt_txt();
		case ($urandom_range(0, 3))
			0: txt[$urandom_range(0, txt.size() - 1)] = rand_bracket();
			1: begin
				txt.delete(txt.size() - 1);
				if (txt.size() == 0)
					txt.push_back(CH_OPEN_SQUARE);
			end
			2: txt.insert($urandom_range(0, txt.size()), closer_of($urandom_range(0, 2)));
			default: txt.push_back(opener_of($urandom_range(0, 2)));
		endcase
	endtask

	task automatic random_string();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			build_nested($urandom_range(1, 8), $urandom_range(1, 8));
		end else if (r < 80) begin
			build_nested($urandom_range(1, 8), $urandom_range(1, 8));
			corrupt_txt();
		end else if (r < 92) begin
			txt.delete();
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 2) == 0)
					txt.push_back(rand_bracket());
				else
					txt.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			build_nested($urandom_range(10, 40), $urandom_range(10, 40));
		end
		send_txt();
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		int budget;
		int waited;
		phase_idle  = '{0, 50, 0, 37};
		phase_stall = '{0, 0, 50, 37};
		sb = new();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty, mismatch and unclosed errors, first error wins, nesting, byte extremes
		send_str(")");
		send_str("{[()]}");
		send_str("(}");
		send_str("[)");
		send_str("{]");
		send_str("([");
		send_str("]([{");
		send_str("(])");
		txt = '{8'h00};
		send_txt();
		txt = '{8'hFF};
		send_txt();
		drain();

		// Random traffic over four idling and stall phases
		for (int p = 0; p < 4; p++) begin
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			budget    = n_sent + 300;
			// full-depth strings: exactly full then closed, overflow then closers, full then a curly pair
			if (p == 1) begin
				build_deep(DEPTH, DEPTH);
				send_txt();
			end else if (p == 2) begin
				build_deep(DEPTH + 1, 2);
				send_txt();
			end else if (p == 3) begin
				build_deep(DEPTH, 0);
				txt.push_back(CH_OPEN_CURLY);
				txt.push_back(CH_CLOSE_CURLY);
				send_txt();
			end
			while (n_sent < budget) begin
				random_string();
				if ($urandom_range(0, 39) == 0)
					drain();
			end
			drain();
		end
		char_valid <= 1'b0;
		stall_pct  = 20;

		waited = 0;
		while (sb.pending_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending_q.size() != 0) begin
			$display("bracket_balance_checker_core_tb NOT OK");
			$finish;
		end else begin
			repeat (20) @(posedge clk);
			if (sb.errors == 0)
				$display("bracket_balance_checker_core_tb OK");
			else
				$display("bracket_balance_checker_core_tb NOT OK");
			$finish;
		end
	end

endmodule
